// ===== hdl/pmtu_pkg.sv =====
// Shared types and constants for the path MTU probe controller.
package pmtu_pkg;

  localparam int unsigned SizeW  = 16;
  localparam int unsigned TimeW  = 64;
  localparam int unsigned PnW    = 62;
  localparam int unsigned PtoW   = 32;
  localparam int unsigned CountW = 4;
  // 3 * timeout and 10 * timeout widths
  localparam int unsigned Pto3W  = PtoW + 2;
  localparam int unsigned Pto10W = PtoW + 4;

  // Configuration register indexes
  localparam logic [1:0] CFG_BASE_MTU    = 2'd0;
  localparam logic [1:0] CFG_CEILING_MTU = 2'd1;
  localparam logic [1:0] CFG_MAX_PROBES  = 2'd2;

  localparam logic [SizeW-1:0]  BASE_MTU_RST    = 16'd1200;
  localparam logic [SizeW-1:0]  CEILING_MTU_RST = 16'd1472;
  localparam logic [CountW-1:0] MAX_PROBES_RST  = 4'd3;
  localparam logic [CountW-1:0] ATTEMPT_MAX     = 4'd15;

  typedef enum logic [2:0] {
    REQ_PROBE_SENT = 3'd0,
    REQ_ACK        = 3'd1,
    REQ_TIMEOUT    = 3'd2,
    REQ_BLACK_HOLE = 3'd3,
    REQ_POLL       = 3'd4
  } pmtu_req_e;

  typedef struct packed {
    logic [SizeW-1:0]  cur_size;
    logic [SizeW-1:0]  ceil_size;
    logic [SizeW-1:0]  cand_size;
    logic              outstanding;
    logic [CountW-1:0] attempts;
    logic [PnW-1:0]    probe_num;
    logic [TimeW-1:0]  deadline;
    logic [TimeW-1:0]  next_probe;
  } pmtu_state_t;

  // Registered event, timeout multiples already formed
  typedef struct packed {
    logic [2:0]        req_type;
    logic [TimeW-1:0]  now;
    logic [PnW-1:0]    pn;
    logic [Pto3W-1:0]  pto3;
    logic [Pto10W-1:0] pto10;
  } pmtu_event_t;

  typedef struct packed {
    logic              probe_due;
    logic [SizeW-1:0]  probe_size;
    logic [SizeW-1:0]  current_mtu;
    logic [TimeW-1:0]  probe_deadline;
    logic              ack_matched;
  } pmtu_result_t;

endpackage

// ===== hdl/pmtu_update.sv =====
// Next-state and result logic for one probe controller event.
module pmtu_update import pmtu_pkg::*; (
  input  pmtu_state_t       state_i,
  input  pmtu_event_t       event_i,
  input  logic [SizeW-1:0]  base_mtu_i,
  input  logic [CountW-1:0] max_probes_i,
  output pmtu_state_t       state_o,
  output pmtu_result_t      result_o
);

  logic [SizeW-1:0] sel_size;
  logic [TimeW:0]   reprobe_sum;
  logic [TimeW-1:0] deadline_sum;
  logic             reprobe_ok;
  logic             time_ok;
  logic             matched;
  pmtu_state_t      nxt;

  // Candidate wins only if it is above the current size
  assign sel_size     = (state_i.cand_size > state_i.cur_size) ? state_i.cand_size
                                                                : state_i.ceil_size;
  assign deadline_sum = event_i.now + TimeW'(event_i.pto3);
  assign reprobe_sum  = {1'b0, event_i.now} + (TimeW+1)'(event_i.pto10);
  // now >= now + d (mod 2^64) only when d is zero or the sum wrapped
  assign reprobe_ok   = (event_i.pto10 == '0) || reprobe_sum[TimeW];

  always_comb begin
    nxt     = state_i;
    matched = 1'b0;
    time_ok = (event_i.now >= state_i.next_probe);
    case (pmtu_req_e'(event_i.req_type))
      REQ_PROBE_SENT: begin
        nxt.cand_size   = sel_size;
        nxt.probe_num   = event_i.pn;
        nxt.outstanding = 1'b1;
        if (state_i.attempts != ATTEMPT_MAX) begin
          nxt.attempts = state_i.attempts + CountW'(1);
        end
        nxt.deadline    = deadline_sum;
      end
      REQ_ACK: begin
        if (state_i.outstanding && (event_i.pn == state_i.probe_num)) begin
          nxt.cur_size    = state_i.cand_size;
          nxt.cand_size   = '0;
          nxt.outstanding = 1'b0;
          nxt.attempts    = '0;
          nxt.deadline    = '0;
          nxt.next_probe  = reprobe_sum[TimeW-1:0];
          matched         = 1'b1;
          time_ok         = reprobe_ok;
        end
      end
      REQ_TIMEOUT: begin
        if (state_i.outstanding && (event_i.now >= state_i.deadline)) begin
          nxt.outstanding = 1'b0;
          nxt.deadline    = '0;
          if (state_i.attempts >= max_probes_i) begin
            nxt.ceil_size = state_i.cur_size;
            nxt.cand_size = '0;
            nxt.attempts  = '0;
          end
          nxt.next_probe  = event_i.now;
          time_ok         = 1'b1;
        end
      end
      REQ_BLACK_HOLE: begin
        if (state_i.cur_size != base_mtu_i) begin
          // no wrap below zero
          nxt.ceil_size   = (state_i.cur_size != '0) ? state_i.cur_size - SizeW'(1) : '0;
          nxt.cur_size    = base_mtu_i;
          nxt.cand_size   = '0;
          nxt.outstanding = 1'b0;
          nxt.attempts    = '0;
          nxt.deadline    = '0;
          nxt.next_probe  = reprobe_sum[TimeW-1:0];
          time_ok         = reprobe_ok;
        end
      end
      default: begin
        // poll and unused codes leave the state alone
      end
    endcase
  end

  assign state_o = nxt;

  // Result reflects the state after the event
  always_comb begin
    result_o.probe_due      = !nxt.outstanding && (nxt.cur_size < nxt.ceil_size) && time_ok;
    result_o.probe_size     = (nxt.cand_size > nxt.cur_size) ? nxt.cand_size : nxt.ceil_size;
    result_o.current_mtu    = nxt.cur_size;
    result_o.probe_deadline = nxt.outstanding ? nxt.deadline : '0;
    result_o.ack_matched    = matched;
  end

endmodule

// ===== hdl/path_mtu_probe_controller_core.sv =====
// Top level of the path MTU probe controller: event register, update, result register.
// An event is held in the event register, then its result in the result register.
// Throughput: one event per cycle unless the output stalls; the state loop is one pass of compare/add logic.
// Back pressure: the input stalls only while both registers hold data and out_stall_i is high.
// Reset: asynchronous active-low; registers return to base 1200, ceiling 1472,
// max probes 3 and an idle probe state. No clearing pass is needed.
module path_mtu_probe_controller_core import pmtu_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration write port
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [SizeW-1:0]  cfg_data_i,
  // event channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        req_type_i,
  input  logic [TimeW-1:0]  now_us_i,
  input  logic [PnW-1:0]    packet_number_i,
  input  logic [PtoW-1:0]   probe_timeout_us_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              probe_due_o,
  output logic [SizeW-1:0]  probe_size_o,
  output logic [SizeW-1:0]  current_mtu_o,
  output logic [TimeW-1:0]  probe_deadline_us_o,
  output logic              ack_matched_o
);

  logic [SizeW-1:0]  base_mtu_q, base_mtu_d;
  logic [SizeW-1:0]  ceiling_mtu_q, ceiling_mtu_d;
  logic [CountW-1:0] max_probes_q;
  logic              reinit;

  pmtu_state_t  state_q, state_upd, state_init;
  pmtu_event_t  ev_q, ev_d;
  logic         ev_valid_q;
  pmtu_result_t res_d, res_q;
  logic         res_valid_q;

  logic in_accept;
  logic advance;

  // Handshake control
  assign advance    = ev_valid_q && (!res_valid_q || !out_stall_i);
  assign in_stall_o = ev_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Configuration values as they stand after this cycle's write
  assign base_mtu_d    = (cfg_we_i && (cfg_index_i == CFG_BASE_MTU)) ? cfg_data_i
                                                                     : base_mtu_q;
  assign ceiling_mtu_d = (cfg_we_i && (cfg_index_i == CFG_CEILING_MTU)) ? cfg_data_i
                                                                        : ceiling_mtu_q;
  assign reinit        = cfg_we_i && ((cfg_index_i == CFG_BASE_MTU) ||
                                      (cfg_index_i == CFG_CEILING_MTU));

  always_comb begin
    state_init             = '0;
    state_init.cur_size    = base_mtu_d;
    state_init.ceil_size   = (ceiling_mtu_d > base_mtu_d) ? ceiling_mtu_d : base_mtu_d;
  end

  // Event payload with 3x and 10x timeout built from shifts
  always_comb begin
    ev_d.req_type = req_type_i;
    ev_d.now      = now_us_i;
    ev_d.pn       = packet_number_i;
    ev_d.pto3     = Pto3W'({probe_timeout_us_i, 1'b0}) + Pto3W'(probe_timeout_us_i);
    ev_d.pto10    = Pto10W'({probe_timeout_us_i, 3'b000}) +
                    Pto10W'({probe_timeout_us_i, 1'b0});
  end

  pmtu_update u_update (
    .state_i      (state_q),
    .event_i      (ev_q),
    .base_mtu_i   (base_mtu_q),
    .max_probes_i (max_probes_q),
    .state_o      (state_upd),
    .result_o     (res_d)
  );

  // Configuration registers and controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_mtu_q            <= BASE_MTU_RST;
      ceiling_mtu_q         <= CEILING_MTU_RST;
      max_probes_q          <= MAX_PROBES_RST;
      state_q.cur_size      <= BASE_MTU_RST;
      state_q.ceil_size     <= CEILING_MTU_RST;
      state_q.cand_size     <= '0;
      state_q.outstanding   <= 1'b0;
      state_q.attempts      <= '0;
      state_q.probe_num     <= '0;
      state_q.deadline      <= '0;
      state_q.next_probe    <= '0;
    end else begin
      base_mtu_q    <= base_mtu_d;
      ceiling_mtu_q <= ceiling_mtu_d;
      if (cfg_we_i && (cfg_index_i == CFG_MAX_PROBES)) begin
        max_probes_q <= cfg_data_i[CountW-1:0];
      end
      if (reinit) begin
        state_q <= state_init;
      end else if (advance) begin
        state_q <= state_upd;
      end
    end
  end

  // Valid flags of the event and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        ev_valid_q <= 1'b1;
      end else if (advance) begin
        ev_valid_q <= 1'b0;
      end
      if (advance) begin
        res_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      ev_q <= ev_d;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o         = res_valid_q;
  assign probe_due_o         = res_q.probe_due;
  assign probe_size_o        = res_q.probe_size;
  assign current_mtu_o       = res_q.current_mtu;
  assign probe_deadline_us_o = res_q.probe_deadline;
  assign ack_matched_o       = res_q.ack_matched;

  // A deadline is only kept while a probe is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !state_q.outstanding |-> (state_q.deadline == '0))
    else $error("deadline held with no probe outstanding");

  // A matched ack closes the probe, so no deadline is reported
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ack_matched_o) |-> (probe_deadline_us_o == '0))
    else $error("ack matched but deadline still reported");

  // A due probe always tries a size above the current one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && probe_due_o) |-> ((probe_size_o > current_mtu_o) &&
                                      (probe_deadline_us_o == '0)))
    else $error("probe due with bad size or outstanding deadline");

  // A new result only appears after an event was held in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(ev_valid_q))
    else $error("result produced without an event");

endmodule
